// ===== src/phh_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phh_pkg
// shared constants, codes and control structs of the pixel hit map histogram
// ----------------------------------------------------------------------------
package phh_pkg;

    // map geometry
    localparam int MAP_COLUMNS = 256;
    localparam int MAP_ROWS    = 256;
    localparam int BIN_DEPTH   = MAP_COLUMNS * MAP_ROWS;
    localparam int ADDR_W      = (BIN_DEPTH > 1) ? $clog2(BIN_DEPTH) : 1;

    // field widths
    localparam int CMD_W      = 2;
    localparam int COORD_W    = 10;
    localparam int TOT_W      = 16;
    localparam int TAG_W      = 16;
    localparam int TOT_USED_W = 11;
    localparam int WEIGHT_W   = 2 * TOT_USED_W;
    localparam int BIN_W      = 32;
    localparam int MODE_W     = 2;

    // stream packing
    localparam int S_FIELDS_W = 2 * COORD_W + TOT_W + TAG_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = BIN_W;

    localparam logic [TOT_USED_W-1:0] TOT_MASK = 11'h7ff;

    // command codes
    localparam logic [CMD_W-1:0] CMD_ACCUM      = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ       = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ_CLEAR = 2'd2;
    localparam logic [CMD_W-1:0] CMD_UNUSED     = 2'd3;

    // weight modes
    localparam logic [MODE_W-1:0] MODE_OCCUPANCY = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TOT       = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TOT_SQ    = 2'd2;
    localparam logic [MODE_W-1:0] MODE_TAG       = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic clear_wr;    // write zero at sweep address, advance sweep
        logic capture;     // take the incoming item
        logic read_en;     // read addressed bin, form weight
        logic write_sum;   // write saturated sum back
        logic write_zero;  // zero the addressed bin
        logic load_out;    // load the result register
    } phh_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clr_done;
        logic is_acc;
        logic is_read;
        logic is_read_clear;
        logic in_map;
        logic hit_ok;
        logic out_free;
    } phh_status_t;

endpackage

// ===== src/phh_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phh_datapath
// bin memory, item registers, weight and saturating add, result register
// ----------------------------------------------------------------------------
module phh_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  phh_pkg::phh_cmd_t                 cmd,
    output phh_pkg::phh_status_t              status,
    input  logic                              cfg_wr_en,
    input  logic [phh_pkg::MODE_W-1:0]        cfg_wr_data,
    input  logic [phh_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic [phh_pkg::CMD_W-1:0]         s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [phh_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                              m_tuser
);

    localparam int LIN_W = 2 * phh_pkg::COORD_W;

    logic [phh_pkg::BIN_W-1:0] bin_mem [phh_pkg::BIN_DEPTH];

    logic [phh_pkg::MODE_W-1:0]     mode_reg;
    logic [phh_pkg::ADDR_W-1:0]     clr_addr_reg;
    logic [phh_pkg::CMD_W-1:0]      command_reg;
    logic                           in_map_reg;
    logic                           tot_nz_reg;
    logic [phh_pkg::ADDR_W-1:0]     idx_reg;
    logic [phh_pkg::TOT_USED_W-1:0] tot_reg;
    logic [phh_pkg::TAG_W-1:0]      tag_reg;
    logic [phh_pkg::WEIGHT_W-1:0]   weight_reg;
    logic [phh_pkg::WEIGHT_W-1:0]   weight_next;
    logic [phh_pkg::BIN_W-1:0]      rd_data_reg;
    logic                           m_tvalid_reg;
    logic [phh_pkg::M_TDATA_W-1:0]  m_tdata_reg;
    logic                           m_tuser_reg;

    logic [phh_pkg::COORD_W-1:0]    col_in;
    logic [phh_pkg::COORD_W-1:0]    row_in;
    logic [phh_pkg::TOT_W-1:0]      tot_in;
    logic [phh_pkg::TAG_W-1:0]      tag_in;
    logic                           in_map_in;
    logic [LIN_W-1:0]               lin_in;
    logic [phh_pkg::BIN_W:0]        sum_wide;
    logic [phh_pkg::BIN_W-1:0]      sum_sat;
    logic                           mem_we;
    logic [phh_pkg::ADDR_W-1:0]     mem_waddr;
    logic [phh_pkg::BIN_W-1:0]      mem_wdata;

    // unpack incoming item, column in the lowest bits
    assign col_in = s_tdata[phh_pkg::COORD_W-1:0];
    assign row_in = s_tdata[2*phh_pkg::COORD_W-1:phh_pkg::COORD_W];
    assign tot_in = s_tdata[2*phh_pkg::COORD_W+phh_pkg::TOT_W-1:2*phh_pkg::COORD_W];
    assign tag_in = s_tdata[phh_pkg::S_FIELDS_W-1:2*phh_pkg::COORD_W+phh_pkg::TOT_W];

    assign in_map_in = (col_in != '0) && (col_in <= phh_pkg::COORD_W'(phh_pkg::MAP_COLUMNS))
                    && (row_in != '0) && (row_in <= phh_pkg::COORD_W'(phh_pkg::MAP_ROWS));

    // row-major bin index, constant multiply
    assign lin_in = LIN_W'(row_in - phh_pkg::COORD_W'(1)) * LIN_W'(phh_pkg::MAP_COLUMNS)
                  + LIN_W'(col_in - phh_pkg::COORD_W'(1));

    always_comb
    begin
        case (mode_reg)
            phh_pkg::MODE_OCCUPANCY: weight_next = phh_pkg::WEIGHT_W'(1);
            phh_pkg::MODE_TOT:       weight_next = phh_pkg::WEIGHT_W'(tot_reg);
            phh_pkg::MODE_TOT_SQ:    weight_next = phh_pkg::WEIGHT_W'(tot_reg) *
                                                   phh_pkg::WEIGHT_W'(tot_reg);
            default:                 weight_next = phh_pkg::WEIGHT_W'(tag_reg);
        endcase
    end

    assign sum_wide = {1'b0, rd_data_reg} + (phh_pkg::BIN_W + 1)'(weight_reg);
    assign sum_sat  = sum_wide[phh_pkg::BIN_W] ? '1 : sum_wide[phh_pkg::BIN_W-1:0];

    assign mem_we    = cmd.clear_wr | cmd.write_sum | cmd.write_zero;
    assign mem_waddr = cmd.clear_wr ? clr_addr_reg : idx_reg;
    assign mem_wdata = cmd.write_sum ? sum_sat : '0;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= phh_pkg::MODE_OCCUPANCY;
            clr_addr_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                mode_reg <= cfg_wr_data;
            end
            if (cmd.clear_wr)
            begin
                clr_addr_reg <= clr_addr_reg + phh_pkg::ADDR_W'(1);
            end
            if (cmd.load_out)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            command_reg <= s_tuser;
            in_map_reg  <= in_map_in;
            tot_nz_reg  <= (tot_in != '0);
            idx_reg     <= lin_in[phh_pkg::ADDR_W-1:0];
            tot_reg     <= tot_in[phh_pkg::TOT_USED_W-1:0] & phh_pkg::TOT_MASK;
            tag_reg     <= tag_in;
        end
        if (cmd.read_en)
        begin
            weight_reg <= weight_next;
        end
        if (cmd.load_out)
        begin
            m_tdata_reg <= in_map_reg ? rd_data_reg : '0;
            m_tuser_reg <= ~in_map_reg;
        end
    end

    // bin memory, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            bin_mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.read_en)
        begin
            rd_data_reg <= bin_mem[idx_reg];
        end
    end

    assign status.clr_done      = (clr_addr_reg == phh_pkg::ADDR_W'(phh_pkg::BIN_DEPTH - 1));
    assign status.is_acc        = (command_reg == phh_pkg::CMD_ACCUM);
    assign status.is_read       = (command_reg == phh_pkg::CMD_READ)
                               || (command_reg == phh_pkg::CMD_READ_CLEAR);
    assign status.is_read_clear = (command_reg == phh_pkg::CMD_READ_CLEAR);
    assign status.in_map        = in_map_reg;
    assign status.hit_ok        = in_map_reg & tot_nz_reg;
    assign status.out_free      = ~m_tvalid_reg | m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ===== src/phh_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phh_controller
// sequencer for the clearing sweep and the per-item read-modify-write
// ----------------------------------------------------------------------------
module phh_controller (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  phh_pkg::phh_status_t status,
    output phh_pkg::phh_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_CLEAR  = 4'b0001,
        ST_IDLE   = 4'b0010,
        ST_LOOKUP = 4'b0100,
        ST_UPDATE = 4'b1000
    } phh_state_t;

    phh_state_t state_reg;
    phh_state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (status.clr_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
                if (s_tvalid)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                // dropped hits and the unused command end here
                cmd.read_en = 1'b1;
                if (status.is_read || (status.is_acc && status.hit_ok))
                begin
                    state_next = ST_UPDATE;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_UPDATE:
            begin
                if (status.is_acc)
                begin
                    cmd.write_sum = 1'b1;
                    state_next    = ST_IDLE;
                end
                else if (status.out_free)
                begin
                    cmd.load_out   = 1'b1;
                    cmd.write_zero = status.is_read_clear & status.in_map;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== src/pixel_hit_map_histogram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_hit_map_histogram
// per-pixel weighted hit map with read and read-and-clear access
// ----------------------------------------------------------------------------
// After reset the block sweeps the whole bin memory to zero, one bin a cycle,
// and takes no transfer until that is done; weight_mode may be written
// meanwhile. Afterwards each item goes through capture, memory read with
// weight forming, then write-back or result load. The registered read of
// the bin memory sets these steps. A read result that finds the output
// register still occupied waits in the last step until the register frees,
// but a finished result never stops the next item from being taken. Hits
// with zero ToT, hits outside the map and command 3 give no result and end
// after the memory read step. Reads outside the map return zero with
// address_invalid set and clear nothing.
// ----------------------------------------------------------------------------
module pixel_hit_map_histogram (
    input  logic                              clk,
    input  logic                              rst_n,
    // weight mode register
    input  logic                              cfg_wr_en,
    input  logic [phh_pkg::MODE_W-1:0]        cfg_wr_data,
    // hit and command stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // column, pixel_row, time_over_threshold, event_tag, zero pad
    input  logic [phh_pkg::S_TDATA_W-1:0]     s_tdata,
    // command
    input  logic [phh_pkg::CMD_W-1:0]         s_tuser,
    // read results
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // bin_value
    output logic [phh_pkg::M_TDATA_W-1:0]     m_tdata,
    // address_invalid
    output logic                              m_tuser
);

    phh_pkg::phh_cmd_t    cmd;
    phh_pkg::phh_status_t status;

    // sequencer: clearing sweep, then one item at a time
    phh_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // bin store, weight, saturating add and result register
    phh_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    // no transfer is taken while the sweep is still running
    assert property (@(posedge clk) disable iff (!rst_n) cmd.clear_wr |-> !s_tready)
        else $error("input transfer possible during clearing sweep");

    // one item at a time: ready drops right after a transfer
    assert property (@(posedge clk) disable iff (!rst_n) (s_tvalid && s_tready) |=> !s_tready)
        else $error("second item taken while one is in flight");

    // a result is never loaded over one that is still waiting
    assert property (@(posedge clk) disable iff (!rst_n) cmd.load_out |-> (!m_tvalid || m_tready))
        else $error("pending result overwritten");

    // out-of-map reads carry a zero value
    assert property (@(posedge clk) disable iff (!rst_n) (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("invalid address result with non-zero value");

endmodule
